>>> rtl/core/gtpc_pkg.sv
package gtpc_pkg;

    localparam int ANGLE_W   = 16;
    localparam int GYRO_W    = 17;
    localparam int HEAD_W    = 18;
    localparam int ERR_W     = 19;
    localparam int MAG_W     = 18;
    localparam int GAIN_W    = 8;
    localparam int POWER_W   = 7;
    localparam int DRIVE_W   = 8;
    localparam int TICK_W    = 16;
    localparam int BAND_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int PROD_W    = MAG_W + GAIN_W;

    localparam logic       FUNC_START = 1'b0;
    localparam logic       FUNC_TICK  = 1'b1;
    localparam logic [3:0] DIR_ADD    = 4'd8;
    localparam logic [3:0] DIR_SUB    = 4'd9;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_POWER      = 3'd0,
        CFG_MIN_POWER      = 3'd1,
        CFG_TIMEOUT_MS     = 3'd2,
        CFG_GAIN_FAR       = 3'd3,
        CFG_GAIN_NEAR      = 3'd4,
        CFG_NEAR_THRESHOLD = 3'd5,
        CFG_SETTLE_BAND    = 3'd6,
        CFG_SETTLE_MS      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [POWER_W-1:0] max_power;
        logic [POWER_W-1:0] min_power;
        logic [TICK_W-1:0]  timeout_ms;
        logic [GAIN_W-1:0]  gain_far;
        logic [GAIN_W-1:0]  gain_near;
        logic [ANGLE_W-1:0] near_threshold;
        logic [BAND_W-1:0]  settle_band;
        logic [TICK_W-1:0]  settle_ms;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        max_power:      7'd87,
        min_power:      7'd22,
        timeout_ms:     16'd3000,
        gain_far:       8'd84,
        gain_near:      8'd102,
        near_threshold: 16'd200,
        settle_band:    10'd10,
        settle_ms:      16'd200
    };

endpackage

>>> rtl/core/gtpc_cfg.sv
module gtpc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gtpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gtpc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output gtpc_pkg::t_cfg                 o_cfg
);
    import gtpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_POWER:      n_cfg.max_power      = i_cfg_data[POWER_W-1:0];
                CFG_MIN_POWER:      n_cfg.min_power      = i_cfg_data[POWER_W-1:0];
                CFG_TIMEOUT_MS:     n_cfg.timeout_ms     = i_cfg_data[TICK_W-1:0];
                CFG_GAIN_FAR:       n_cfg.gain_far       = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_NEAR:      n_cfg.gain_near      = i_cfg_data[GAIN_W-1:0];
                CFG_NEAR_THRESHOLD: n_cfg.near_threshold = i_cfg_data[ANGLE_W-1:0];
                CFG_SETTLE_BAND:    n_cfg.settle_band    = i_cfg_data[BAND_W-1:0];
                CFG_SETTLE_MS:      n_cfg.settle_ms      = i_cfg_data[TICK_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/core/gtpc_drive.sv
module gtpc_drive (
    input  logic [gtpc_pkg::MAG_W-1:0]   i_err_mag,
    input  logic                         i_err_neg,
    input  logic [gtpc_pkg::GAIN_W-1:0]  i_gain,
    input  logic [gtpc_pkg::POWER_W-1:0] i_min_power,
    input  logic [gtpc_pkg::POWER_W-1:0] i_max_power,
    output logic [gtpc_pkg::DRIVE_W-1:0] o_drive
);
    import gtpc_pkg::*;

    logic [PROD_W-1:0]          prod;
    logic [PROD_W-GAIN_W-1:0]   q_mag;
    logic [PROD_W-GAIN_W-1:0]   lo_mag;
    logic [POWER_W-1:0]         mag;

    // magnitude path: truncation toward zero is a plain shift
    assign prod = PROD_W'(i_err_mag) * PROD_W'(i_gain);
    assign q_mag = prod[PROD_W-1:GAIN_W];

    always_comb begin
        lo_mag = q_mag;
        if (q_mag != '0 && q_mag < (PROD_W-GAIN_W)'(i_min_power)) begin
            lo_mag = (PROD_W-GAIN_W)'(i_min_power);
        end
        if (lo_mag > (PROD_W-GAIN_W)'(i_max_power)) begin
            mag = i_max_power;
        end else begin
            mag = lo_mag[POWER_W-1:0];
        end
    end

    assign o_drive = i_err_neg ? (DRIVE_W'(0) - {1'b0, mag}) : {1'b0, mag};

endmodule

>>> rtl/core/gyro_turn_p_controller.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   func, direction, target_degrees, gyro_reading
// result    out        o_out_valid / i_out_stall left_power, right_power, busy_res, timed_out
// config    in         i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled.
// Stage one registers the item, stage two updates turn state, runs the gain multiply
// and power clamp, and registers the result.
// Reset (synchronous, active low) restores register defaults and clears turn state.
// A stalled result holds stage two; stage one still takes one more item behind it.
module gyro_turn_p_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_func,
    input  logic [3:0]                           i_direction,
    input  logic [gtpc_pkg::ANGLE_W-1:0]         i_target_degrees,
    input  logic signed [gtpc_pkg::GYRO_W-1:0]   i_gyro_reading,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [gtpc_pkg::DRIVE_W-1:0]  o_left_power,
    output logic signed [gtpc_pkg::DRIVE_W-1:0]  o_right_power,
    output logic                                 o_busy_res,
    output logic                                 o_timed_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gtpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gtpc_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import gtpc_pkg::*;

    t_cfg cfg;

    logic                      r_in_valid;
    logic                      r_func;
    logic [3:0]                r_direction;
    logic [ANGLE_W-1:0]        r_angle;
    logic signed [GYRO_W-1:0]  r_gyro;

    logic signed [HEAD_W-1:0]  r_target, n_target;
    logic                      r_near, n_near;
    logic                      r_running, n_running;
    logic [TICK_W-1:0]         r_elapsed, n_elapsed;
    logic [TICK_W-1:0]         r_settle, n_settle;
    logic                      r_tflag, n_tflag;

    logic                      r_out_valid;
    logic [DRIVE_W-1:0]        r_left, n_left;
    logic                      r_busy, n_busy;
    logic                      r_tmo, n_tmo;

    logic                      adv;
    logic                      in_accept;
    logic signed [ERR_W-1:0]   err;
    logic [MAG_W-1:0]          err_mag;
    logic [ERR_W-1:0]          err_abs;
    logic [DRIVE_W-1:0]        drive;
    logic [TICK_W-1:0]         settle_inc;

    gtpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign err     = ERR_W'(r_target) - ERR_W'(r_gyro);
    assign err_abs = err[ERR_W-1] ? (ERR_W'(0) - err) : err;
    assign err_mag = err_abs[MAG_W-1:0];

    gtpc_drive u_drive (
        .i_err_mag   (err_mag),
        .i_err_neg   (err[ERR_W-1]),
        .i_gain      (r_near ? cfg.gain_near : cfg.gain_far),
        .i_min_power (cfg.min_power),
        .i_max_power (cfg.max_power),
        .o_drive     (drive)
    );

    always_comb begin
        n_target  = r_target;
        n_near    = r_near;
        n_running = r_running;
        n_elapsed = r_elapsed;
        n_settle  = r_settle;
        n_tflag   = r_tflag;
        n_left    = '0;
        n_busy    = 1'b0;
        n_tmo     = 1'b0;
        settle_inc = (r_settle == TICK_MAX) ? r_settle : r_settle + 1'b1;
        priority if (r_func == FUNC_START) begin
            n_target = HEAD_W'(r_gyro);
            if (r_direction == DIR_ADD) begin
                n_target = HEAD_W'(r_gyro) + HEAD_W'(r_angle);
            end else if (r_direction == DIR_SUB) begin
                n_target = HEAD_W'(r_gyro) - HEAD_W'(r_angle);
            end
            n_near    = r_angle < cfg.near_threshold;
            n_running = 1'b1;
            n_elapsed = '0;
            n_settle  = '0;
            n_tflag   = 1'b0;
            n_busy    = 1'b1;
        end else if (!r_running) begin
            n_tmo = r_tflag;
        end else if (r_elapsed >= cfg.timeout_ms) begin
            n_running = 1'b0;
            n_tflag   = 1'b1;
            n_tmo     = 1'b1;
        end else begin
            n_settle  = (err_mag > MAG_W'(cfg.settle_band)) ? '0 : settle_inc;
            n_elapsed = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 1'b1;
            if (n_settle > cfg.settle_ms) begin
                n_running = 1'b0;
            end else begin
                n_left = drive;
                n_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_target    <= '0;
            r_near      <= 1'b0;
            r_running   <= 1'b0;
            r_elapsed   <= '0;
            r_settle    <= '0;
            r_tflag     <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_in_valid;
                r_in_valid  <= in_accept;
            end else if (in_accept) begin
                r_in_valid <= 1'b1;
            end
            if (adv && r_in_valid) begin
                r_target  <= n_target;
                r_near    <= n_near;
                r_running <= n_running;
                r_elapsed <= n_elapsed;
                r_settle  <= n_settle;
                r_tflag   <= n_tflag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func      <= i_func;
            r_direction <= i_direction;
            r_angle     <= i_target_degrees;
            r_gyro      <= i_gyro_reading;
        end
        if (adv && r_in_valid) begin
            r_left <= n_left;
            r_busy <= n_busy;
            r_tmo  <= n_tmo;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_power  = r_left;
    assign o_right_power = DRIVE_W'(0) - r_left;
    assign o_busy_res    = r_busy;
    assign o_timed_out   = r_tmo;

`ifndef SYNTHESIS
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_left_power == '0)
        else $error("idle result carries nonzero drive");

    a_tmo_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timed_out |-> !o_busy_res)
        else $error("timeout result flagged busy");

    a_run_ends_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_running) |-> $past(adv && r_in_valid))
        else $error("turn ended without a processed beat");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> $stable(r_elapsed) && $stable(r_settle))
        else $error("turn state moved while result stalled");
`endif

endmodule

>>> bench/gyro_turn_p_controller_tb.sv
`timescale 1ns / 100ps

import gtpc_pkg::*;

typedef struct packed {
    logic signed [DRIVE_W-1:0] left_pw;
    logic signed [DRIVE_W-1:0] right_pw;
    logic                      busy;
    logic                      timed_out;
} t_drive;

class heading_tracker;
    t_cfg        regs;
    int          heading;
    bit          near_pick;
    bit          turning;
    bit          aborted;
    int unsigned elapsed;
    int unsigned in_band;
    t_drive      pending[$];
    int unsigned faults;

    function new();
        regs      = CFG_RESET;
        heading   = 0;
        near_pick = 1'b0;
        turning   = 1'b0;
        aborted   = 1'b0;
        elapsed   = 0;
        in_band   = 0;
        faults    = 0;
    endfunction

    function void set_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] v);
        case (idx)
            CFG_MAX_POWER:      regs.max_power      = POWER_W'(v);
            CFG_MIN_POWER:      regs.min_power      = POWER_W'(v);
            CFG_TIMEOUT_MS:     regs.timeout_ms     = TICK_W'(v);
            CFG_GAIN_FAR:       regs.gain_far       = GAIN_W'(v);
            CFG_GAIN_NEAR:      regs.gain_near      = GAIN_W'(v);
            CFG_NEAR_THRESHOLD: regs.near_threshold = ANGLE_W'(v);
            CFG_SETTLE_BAND:    regs.settle_band    = BAND_W'(v);
            default:            regs.settle_ms      = TICK_W'(v);
        endcase
    endfunction

    function void take_item(logic func, logic [3:0] dir, logic [ANGLE_W-1:0] angle,
                            logic signed [GYRO_W-1:0] gyro);
        int     g;
        int     err;
        int     d;
        int     mag;
        int     mn;
        int     mx;
        t_drive drv;
        g   = int'(gyro);
        drv = '0;
        if (func == FUNC_START) begin
            heading = g;
            if (dir == DIR_ADD) begin
                heading += int'(angle);
            end else if (dir == DIR_SUB) begin
                heading -= int'(angle);
            end
            near_pick = angle < regs.near_threshold;
            turning   = 1'b1;
            elapsed   = 0;
            in_band   = 0;
            aborted   = 1'b0;
            drv.busy  = 1'b1;
        end else if (!turning) begin
            drv.timed_out = aborted;
        end else if (elapsed >= regs.timeout_ms) begin
            turning       = 1'b0;
            aborted       = 1'b1;
            drv.timed_out = 1'b1;
        end else begin
            err = heading - g;
            d   = err * int'(near_pick ? regs.gain_near : regs.gain_far) / 256;
            mn  = int'(regs.min_power);
            mx  = int'(regs.max_power);
            if (d > 0 && d < mn) begin
                d = mn;
            end else if (d < 0 && d > -mn) begin
                d = -mn;
            end
            if (d > mx) begin
                d = mx;
            end else if (d < -mx) begin
                d = -mx;
            end
            mag = err < 0 ? -err : err;
            if (mag > int'(regs.settle_band)) begin
                in_band = 0;
            end else if (in_band < TICK_MAX) begin
                in_band++;
            end
            if (elapsed < TICK_MAX) begin
                elapsed++;
            end
            if (in_band > regs.settle_ms) begin
                turning = 1'b0;
            end else begin
                drv.left_pw  = DRIVE_W'(d);
                drv.right_pw = DRIVE_W'(-d);
                drv.busy     = 1'b1;
            end
        end
        pending.push_back(drv);
    endfunction

    task flag_mismatch(string msg);
        if (faults < 40) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        faults++;
    endtask

    task match_drive(t_drive got);
        t_drive want;
        if (pending.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat left=%0d right=%0d busy=%b tmo=%b",
                                    got.left_pw, got.right_pw, got.busy, got.timed_out));
            return;
        end
        want = pending.pop_front();
        if (got.left_pw !== want.left_pw) begin
            flag_mismatch($sformatf("left_power got %0d want %0d", got.left_pw, want.left_pw));
        end
        if (got.right_pw !== want.right_pw) begin
            flag_mismatch($sformatf("right_power got %0d want %0d",
                                    got.right_pw, want.right_pw));
        end
        if (got.busy !== want.busy) begin
            flag_mismatch($sformatf("busy_res got %b want %b", got.busy, want.busy));
        end
        if (got.timed_out !== want.timed_out) begin
            flag_mismatch($sformatf("timed_out got %b want %b", got.timed_out, want.timed_out));
        end
    endtask
endclass

module gyro_turn_p_controller_tb;

    typedef enum {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} t_idle;

    localparam logic [3:0] DIR_HOLD = 4'd3;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_func;
    logic [3:0]                  i_direction;
    logic [ANGLE_W-1:0]          i_target_degrees;
    logic signed [GYRO_W-1:0]    i_gyro_reading;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [DRIVE_W-1:0]   o_left_power;
    logic signed [DRIVE_W-1:0]   o_right_power;
    logic                        o_busy_res;
    logic                        o_timed_out;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DAT_W-1:0]        i_cfg_data;

    heading_tracker tracker = new();
    t_idle          idle_mode = IDLE_SEND_LIGHT;
    int unsigned    sent = 0;

    gyro_turn_p_controller u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_direction      (i_direction),
        .i_target_degrees (i_target_degrees),
        .i_gyro_reading   (i_gyro_reading),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_power     (o_left_power),
        .o_right_power    (o_right_power),
        .o_busy_res       (o_busy_res),
        .o_timed_out      (o_timed_out),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int gap_pct();
        return idle_mode == IDLE_SEND_LIGHT ? 8 : idle_mode == IDLE_SEND_HEAVY ? 49 : 0;
    endfunction

    function automatic int stall_pct();
        return idle_mode == IDLE_SEND_LIGHT ? 49 : idle_mode == IDLE_SEND_HEAVY ? 8 : 0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.match_drive('{o_left_power, o_right_power, o_busy_res, o_timed_out});
        end
        i_out_stall <= $urandom_range(0, 99) < stall_pct();
    end

    task automatic push_item(logic func, logic [3:0] dir, logic [ANGLE_W-1:0] angle,
                             logic signed [GYRO_W-1:0] gyro);
        if ($urandom_range(0, 99) < gap_pct()) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= func;
        i_direction      <= dir;
        i_target_degrees <= angle;
        i_gyro_reading   <= gyro;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_item(func, dir, angle, gyro);
        sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_regs(t_cfg c);
        t_cfg_idx             idx;
        logic [CFG_DAT_W-1:0] v;
        for (int k = 0; k < idx.num(); k++) begin
            idx = t_cfg_idx'(k);
            v   = CFG_DAT_W'($urandom);
            case (idx)
                CFG_MAX_POWER:      v[POWER_W-1:0] = c.max_power;
                CFG_MIN_POWER:      v[POWER_W-1:0] = c.min_power;
                CFG_TIMEOUT_MS:     v = c.timeout_ms;
                CFG_GAIN_FAR:       v[GAIN_W-1:0] = c.gain_far;
                CFG_GAIN_NEAR:      v[GAIN_W-1:0] = c.gain_near;
                CFG_NEAR_THRESHOLD: v = c.near_threshold;
                CFG_SETTLE_BAND:    v[BAND_W-1:0] = c.settle_band;
                default:            v = c.settle_ms;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= v;
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.set_reg(idx, v);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // start, then ticks that close in on the target and mostly sit in the band
    task automatic run_turn();
        int                 origin;
        int                 aim;
        int                 pos;
        int                 band;
        int                 span;
        int                 pick;
        logic [3:0]         dir;
        logic [ANGLE_W-1:0] angle;
        band   = int'(tracker.regs.settle_band);
        origin = int'($urandom_range(0, 72000)) - 36000;
        pick   = $urandom_range(0, 9);
        dir    = pick < 4 ? DIR_ADD : pick < 8 ? DIR_SUB : 4'($urandom);
        if ($urandom_range(0, 1)) begin
            angle = ANGLE_W'($urandom_range(0, tracker.regs.near_threshold));
        end else begin
            angle = ANGLE_W'($urandom_range(0, 36000));
        end
        aim = origin;
        if (dir == DIR_ADD) begin
            aim += int'(angle);
        end else if (dir == DIR_SUB) begin
            aim -= int'(angle);
        end
        push_item(FUNC_START, dir, angle, GYRO_W'(origin));
        pos  = origin;
        span = $urandom_range(1, 60);
        for (int i = 0; i < span; i++) begin
            if (i >= span / 4 && $urandom_range(0, 99) < 95) begin
                pos = aim + int'($urandom_range(0, 2 * band)) - band;
            end else begin
                pos = pos + (aim - pos) / 2 + int'($urandom_range(0, 8)) - 4;
            end
            if (pos > 65535) begin
                pos = 65535;
            end else if (pos < -65536) begin
                pos = -65536;
            end
            push_item(FUNC_TICK, 4'($urandom), ANGLE_W'($urandom), GYRO_W'(pos));
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 4)) begin
            push_item(1'($urandom), 4'($urandom), ANGLE_W'($urandom), GYRO_W'($urandom));
        end
    endtask

    initial begin
        #400_000;
        $display("gyro_turn_p_controller_tb: errors");
        $finish;
    end

    initial begin
        t_cfg        regs_set;
        int unsigned goal;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_func           <= FUNC_START;
        i_direction      <= DIR_HOLD;
        i_target_degrees <= '0;
        i_gyro_reading   <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_MAX_POWER;
        i_cfg_data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values
        push_item(FUNC_TICK,  DIR_HOLD, 0,      0);
        push_item(FUNC_START, DIR_ADD,  900,    0);
        push_item(FUNC_TICK,  DIR_HOLD, 0,      0);
        push_item(FUNC_TICK,  DIR_HOLD, 0,      880);
        push_item(FUNC_TICK,  DIR_HOLD, 0,      920);
        push_item(FUNC_TICK,  DIR_HOLD, 0,      897);
        push_item(FUNC_START, DIR_SUB,  100,    -500);
        push_item(FUNC_TICK,  DIR_HOLD, 0,      -36000);
        push_item(FUNC_TICK,  DIR_HOLD, 0,      36000);
        push_item(FUNC_START, DIR_HOLD, 36000,  36000);
        push_item(FUNC_TICK,  DIR_HOLD, 0,      -36000);
        push_item(FUNC_START, DIR_ADD,  16'hFFFF, 65535);
        push_item(FUNC_TICK,  DIR_HOLD, 0,      -65536);
        push_item(FUNC_START, DIR_HOLD, 0,      -65536);
        wait_drained();

        // min above max, settle exit, timeout exit, zero gain
        regs_set = '{max_power: 30, min_power: 50, timeout_ms: 3, gain_far: 255,
                     gain_near: 0, near_threshold: 500, settle_band: 0, settle_ms: 1};
        load_regs(regs_set);
        push_item(FUNC_START, DIR_ADD,  1000, 0);
        push_item(FUNC_TICK,  DIR_HOLD, 0,    996);
        push_item(FUNC_TICK,  DIR_HOLD, 0,    1000);
        push_item(FUNC_TICK,  DIR_HOLD, 0,    1000);
        push_item(FUNC_TICK,  DIR_HOLD, 0,    5);
        push_item(FUNC_START, DIR_SUB,  100,  0);
        repeat (4) push_item(FUNC_TICK, DIR_HOLD, 0, 200);
        push_item(FUNC_TICK,  DIR_HOLD, 0,    5);
        wait_drained();

        goal = sent;
        for (int ph = 0; ph < 6; ph++) begin
            idle_mode = ph < 2 ? IDLE_SEND_LIGHT : ph < 4 ? IDLE_SEND_HEAVY : IDLE_NONE;
            if (ph == 1) begin
                regs_set = '1;
            end else if (ph == 3) begin
                regs_set = '0;
            end else begin
                regs_set.max_power      = POWER_W'($urandom_range(10, 127));
                regs_set.min_power      = POWER_W'($urandom_range(0, 80));
                regs_set.timeout_ms     = TICK_W'($urandom_range(0, 60));
                regs_set.gain_far       = GAIN_W'($urandom_range(0, 255));
                regs_set.gain_near      = GAIN_W'($urandom_range(0, 255));
                regs_set.near_threshold = ANGLE_W'($urandom_range(0, 3000));
                regs_set.settle_band    = BAND_W'($urandom_range(0, 80));
                regs_set.settle_ms      = TICK_W'($urandom_range(0, 12));
            end
            load_regs(regs_set);
            goal += 205;
            while (sent < goal) begin
                if ($urandom_range(0, 99) < 80) begin
                    run_turn();
                end else begin
                    run_noise();
                end
            end
            wait_drained();
        end

        if (tracker.faults == 0) begin
            $display("gyro_turn_p_controller_tb: clean");
        end else begin
            $display("gyro_turn_p_controller_tb: errors");
        end
        $finish;
    end

endmodule
